[hdl/sirc_pkg.sv]
`timescale 1ns / 1ps

package sirc_pkg;

    localparam int FRAME_BITS   = 12;
    localparam int IV_W         = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int ADDR_W       = 5;
    localparam int KEY_W        = 7;
    localparam int RPT_W        = 8;
    localparam int SHIFT_W      = 16;
    localparam int BCNT_W       = 4;
    localparam int PHASE_W      = 5;
    localparam int WIN_W        = IV_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LONG     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SHORT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MID      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REMAP_ENABLE = 3'd5;

    localparam logic [IV_W-1:0] HEADER_LEN_RST = 16'd2400;
    localparam logic [IV_W-1:0] TOLERANCE_RST  = 16'd200;
    localparam logic [IV_W-1:0] BIT_LONG_RST   = 16'd1200;
    localparam logic [IV_W-1:0] BIT_SHORT_RST  = 16'd600;
    localparam logic [IV_W-1:0] BIT_MID_RST    = 16'd900;

    localparam logic [BCNT_W-1:0]  BCNT_DONE    = 4'(FRAME_BITS);
    localparam logic [PHASE_W-1:0] PHASE_HEADER = 5'd1;
    localparam logic [PHASE_W-1:0] PHASE_FIRST  = 5'd2;

    typedef enum logic [1:0] {
        FS_OK      = 2'd0,
        FS_END     = 2'd1,
        FS_RESTART = 2'd2
    } t_frame_state;

    typedef struct packed {
        logic            mode;
        logic [IV_W-1:0] interval;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] dev_address;
        logic [KEY_W-1:0]  key_code;
        logic [RPT_W-1:0]  repeat_count;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] adr;
        logic [KEY_W-1:0]  cmd;
        logic              toggle;
    } t_frame;

    typedef struct packed {
        logic [IV_W-1:0] header_len;
        logic [IV_W-1:0] tolerance;
        logic [IV_W-1:0] bit_long;
        logic [IV_W-1:0] bit_short;
        logic [IV_W-1:0] bit_mid;
    } t_timing;

    function automatic logic [KEY_W-1:0] remap_key(input logic [KEY_W-1:0] c);
        logic [KEY_W-1:0] r;
        r = c;
        if (c <= 7'd8) begin
            r = c + 7'd1;
        end else begin
            case (c)
                7'd9:    r = 7'd0;
                7'd18:   r = 7'd16;
                7'd19:   r = 7'd17;
                7'd16:   r = 7'd32;
                7'd17:   r = 7'd33;
                7'd21:   r = 7'd12;
                7'd96:   r = 7'd36;
                7'd20:   r = 7'd13;
                7'd29:   r = 7'd10;
                7'd101:  r = 7'd59;
                7'd76:   r = 7'd55;
                7'd77:   r = 7'd54;
                7'd78:   r = 7'd50;
                7'd79:   r = 7'd52;
                7'd52:   r = 7'd17;
                7'd51:   r = 7'd16;
                7'd116:  r = 7'd32;
                7'd117:  r = 7'd33;
                default: r = c;
            endcase
        end
        return r;
    endfunction

endpackage

[hdl/sirc_ir_frame_decoder_unit.sv]
`timescale 1ns / 1ps
// A frame's result is written into the queue as its last bit is accepted and is then registered at the output.
// The edge decoder accepts one input item per cycle while the queue is not full and updates its state on each one.
// A two-entry queue and the output register let input and output stall independently.
// Reset is synchronous and active low; it restores the default timing registers and
// returns the decoder to hunting with an empty queue.

module sirc_ir_frame_decoder_unit
    import sirc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [IV_W-1:0]      i_cfg_data
);

    t_timing r_timing;
    logic    r_remap;
    logic    push, pop, full, empty;
    t_frame  fe_frame, q_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.header_len <= HEADER_LEN_RST;
            r_timing.tolerance  <= TOLERANCE_RST;
            r_timing.bit_long   <= BIT_LONG_RST;
            r_timing.bit_short  <= BIT_SHORT_RST;
            r_timing.bit_mid    <= BIT_MID_RST;
            r_remap             <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEADER_LEN:   r_timing.header_len <= i_cfg_data;
                REG_TOLERANCE:    r_timing.tolerance  <= i_cfg_data;
                REG_BIT_LONG:     r_timing.bit_long   <= i_cfg_data;
                REG_BIT_SHORT:    r_timing.bit_short  <= i_cfg_data;
                REG_BIT_MID:      r_timing.bit_mid    <= i_cfg_data;
                REG_REMAP_ENABLE: r_remap             <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !full;

    sirc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid && !full),
        .i_item   (i_in_data),
        .i_timing (r_timing),
        .o_push   (push),
        .o_frame  (fe_frame)
    );

    sirc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (fe_frame),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_frame (q_frame)
    );

    sirc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_remap (r_remap),
        .i_empty (empty),
        .i_frame (q_frame),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

[hdl/sirc_front.sv]
`timescale 1ns / 1ps

module sirc_front
    import sirc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_timing  i_timing,
    output logic     o_push,
    output t_frame   o_frame
);

    t_frame_state        r_fs, n_fs;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic                r_hs, n_hs;
    logic [SHIFT_W-1:0]  r_sd, n_sd;
    logic [BCNT_W-1:0]   r_bc, n_bc;
    logic                r_toggle, n_toggle;
    logic                r_armed, n_armed;

    logic signed [WIN_W-1:0] iv, hdr_lo, hdr_hi, win_hi, win_lo, mid;
    logic                    hdr_hit, out_win, is_one;

    assign iv     = $signed({2'b00, i_item.interval});
    assign hdr_lo = $signed({2'b00, i_timing.header_len}) - $signed({2'b00, i_timing.tolerance});
    assign hdr_hi = $signed({2'b00, i_timing.header_len}) + $signed({2'b00, i_timing.tolerance});
    assign win_hi = $signed({2'b00, i_timing.bit_long}) + $signed({2'b00, i_timing.tolerance});
    assign win_lo = $signed({2'b00, i_timing.bit_short}) - $signed({2'b00, i_timing.tolerance});
    assign mid    = $signed({2'b00, i_timing.bit_mid});

    assign hdr_hit = (r_phase == PHASE_HEADER) && (iv > hdr_lo) && (iv < hdr_hi);
    assign out_win = (iv > win_hi) || (iv < win_lo);
    assign is_one  = iv > mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs     <= FS_RESTART;
            r_phase  <= '0;
            r_hs     <= 1'b0;
            r_sd     <= '0;
            r_bc     <= '0;
            r_toggle <= 1'b0;
            r_armed  <= 1'b1;
        end else begin
            r_fs     <= n_fs;
            r_phase  <= n_phase;
            r_hs     <= n_hs;
            r_sd     <= n_sd;
            r_bc     <= n_bc;
            r_toggle <= n_toggle;
            r_armed  <= n_armed;
        end
    end

    always_comb begin
        n_fs     = r_fs;
        n_phase  = r_phase;
        n_hs     = r_hs;
        n_sd     = r_sd;
        n_bc     = r_bc;
        n_toggle = r_toggle;
        n_armed  = r_armed;
        o_push   = 1'b0;
        if (i_valid) begin
            if (i_item.mode) begin
                if (r_armed) begin
                    n_phase  = '0;
                    n_toggle = ~r_toggle;
                    n_armed  = 1'b0;
                end
            end else begin
                n_armed = 1'b1;
                if (r_hs && (r_phase == PHASE_FIRST)) begin
                    n_fs = FS_OK;
                end
                if (hdr_hit) begin
                    n_sd = '0;
                    n_bc = '0;
                    n_fs = FS_END;
                    n_hs = 1'b1;
                end
                if (n_fs == FS_OK) begin
                    if (out_win) begin
                        n_fs = FS_RESTART;
                    end else if (r_phase[0]) begin
                        n_sd = {is_one, n_sd[SHIFT_W-1:1]};
                        n_bc = n_bc + 4'd1;
                        if (n_bc == BCNT_DONE) begin
                            o_push = 1'b1;
                            n_fs   = FS_RESTART;
                        end
                    end
                end
                if (n_fs == FS_RESTART) begin
                    n_phase = '0;
                    n_hs    = 1'b0;
                end
                n_phase = n_phase + 5'd1;
            end
        end
    end

    assign o_frame.adr    = n_sd[15:11];
    assign o_frame.cmd    = n_sd[10:4];
    assign o_frame.toggle = r_toggle;

endmodule

[hdl/sirc_queue.sv]
`timescale 1ns / 1ps

module sirc_queue
    import sirc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_frame o_frame
);

    t_frame      r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;
    logic        do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_frame = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule

[hdl/sirc_back.sv]
`timescale 1ns / 1ps

module sirc_back
    import sirc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_remap,
    input  logic      i_empty,
    input  t_frame    i_frame,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic             r_valid;
    logic             r_last_toggle;
    logic [RPT_W-1:0] r_rpt, n_rpt;
    t_out_item        r_item;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign n_rpt   = (r_last_toggle == i_frame.toggle) ? r_rpt + 8'd1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_last_toggle <= 1'b0;
            r_rpt         <= '0;
        end else begin
            if (o_pop) begin
                r_valid       <= 1'b1;
                r_last_toggle <= i_frame.toggle;
                r_rpt         <= n_rpt;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item.repeat_count <= n_rpt;
            if (i_remap) begin
                r_item.dev_address <= (i_frame.adr == 5'd1 || i_frame.adr == 5'd3) ?
                                      '0 : i_frame.adr;
                r_item.key_code    <= remap_key(i_frame.cmd);
            end else begin
                r_item.dev_address <= i_frame.adr;
                r_item.key_code    <= i_frame.cmd;
            end
        end
    end

endmodule
